[rtl/core/fac_pkg.sv]
// Shared types and constants for the fader ADC conditioner.
// Used by fac_div, fader_adc_conditioner and its testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package fac_pkg;

	// Operating modes carried by an input word.
	localparam logic [2:0] MODE_SAMPLE   = 3'd0;
	localparam logic [2:0] MODE_CAP_LOW  = 3'd1;
	localparam logic [2:0] MODE_CAP_HIGH = 3'd2;
	localparam logic [2:0] MODE_LOAD_LOW = 3'd3;
	localparam logic [2:0] MODE_LOAD_HI  = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] REG_ALPHA     = 2'd0;
	localparam logic [1:0] REG_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_DEAD_PCT  = 2'd2;
	localparam logic [1:0] REG_MIN_SPAN  = 2'd3;

	// Configuration reset values.
	localparam logic [8:0]  ALPHA_RST     = 9'd77;
	localparam logic [15:0] THRESHOLD_RST = 16'd256;
	localparam logic [5:0]  DEAD_PCT_RST  = 6'd2;
	localparam logic [14:0] MIN_SPAN_RST  = 15'd10;

	// Output word kinds.
	localparam logic KIND_LEVEL   = 1'b0;
	localparam logic KIND_CAPTURE = 1'b1;

	// Fixed-point constants.
	localparam logic [8:0]  ALPHA_MAX   = 9'd256;
	localparam logic [15:0] FULL_Q8     = 16'd65280;
	localparam logic [39:0] UNCAL_ROUND = 40'd16383;
	localparam logic [23:0] UNCAL_DEN   = 24'd32767;
	localparam logic [39:0] PCT_ROUND   = 40'd50;
	localparam logic [23:0] PCT_DEN     = 24'd100;

	// Serial divider geometry: 40-bit dividend, 24-bit divisor and quotient.
	localparam int DIV_NUM_W = 40;
	localparam int DIV_DEN_W = 24;
	localparam int DIV_STEPS = 24;

	typedef struct packed {
		logic [2:0]         mode;
		logic [1:0]         channel;
		logic signed [15:0] sample;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  chan_out;
		logic [7:0]  level;
		logic        send;
		logic        display_update;
		logic [14:0] captured_raw;
		logic        last;
	} res_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

endpackage

`default_nettype wire

[rtl/core/fac_div.sv]
// Restoring serial divider, one quotient bit per clock.
// Depends on fac_pkg for the request type and the divider geometry.
`timescale 1ns / 1ps
`default_nettype none

module fac_div (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire fac_pkg::div_req_t                  req,
	output logic                                    done,
	output logic [fac_pkg::DIV_DEN_W-1:0]           quot
);

	localparam int CNT_W = $clog2(fac_pkg::DIV_STEPS + 1);
	localparam int HI_W  = fac_pkg::DIV_NUM_W - fac_pkg::DIV_STEPS;

	logic [CNT_W-1:0]                cnt_q;
	logic                            done_q;
	logic [fac_pkg::DIV_DEN_W-1:0]   rem_q;
	logic [fac_pkg::DIV_STEPS-1:0]   shl_q;
	logic [fac_pkg::DIV_DEN_W-1:0]   den_q;
	logic [fac_pkg::DIV_DEN_W:0]     trial;
	logic                            fits;

	// The partial remainder takes the next dividend bit; subtract when the divisor fits.
	always_comb begin
		trial = {rem_q, shl_q[fac_pkg::DIV_STEPS-1]};
		fits  = trial >= {1'b0, den_q};
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= CNT_W'(fac_pkg::DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath. The caller guarantees the quotient fits in DIV_STEPS bits, so the
	// upper dividend bits are already below the divisor and seed the remainder.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= fac_pkg::DIV_DEN_W'(req.num[fac_pkg::DIV_NUM_W-1 -: HI_W]);
			shl_q <= req.num[fac_pkg::DIV_STEPS-1:0];
			den_q <= req.den;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= fac_pkg::DIV_DEN_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[fac_pkg::DIV_DEN_W-1:0];
			end
			shl_q <= {shl_q[fac_pkg::DIV_STEPS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = fac_pkg::DIV_DEN_W'(shl_q);

endmodule

`default_nettype wire

[rtl/core/fader_adc_conditioner.sv]
// Fader conditioner: clamps each ADC reading, smooths it with an exponential
// average per channel and maps it to a 0..255 level, uncalibrated over full
// scale or calibrated between stored low and high bounds with a dead zone at
// each end. Capture words latch every channel's last raw reading as a bound and
// report it, one word per channel; load words restore one bound and give no
// result. One input word is handled at a time. A sample uses the 24-step serial
// divider once for full-scale mapping; calibrated, it divides for the dead zone
// and then for the level, skipping both when the span is too short and the second
// when the reading lies outside the dead-zone edges. A load or an ignored word is handled in the idle state.
// Depends on fac_pkg and fac_div.
`timescale 1ns / 1ps
`default_nettype none

module fader_adc_conditioner #(
	parameter int CHANNELS = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire fac_pkg::req_t   req,
	output logic                 res_valid,
	input  wire logic            res_ready,
	output fac_pkg::res_t        res,
	input  wire logic            cfg_we,
	input  wire logic [1:0]      cfg_idx,
	input  wire logic [15:0]     cfg_data
);

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EMA,
		S_UPD,
		S_MAP,
		S_DIV,
		S_CMP,
		S_NUM,
		S_FIN,
		S_CAP
	} state_t;

	// Configuration registers.
	logic [8:0]  alpha_q;
	logic [15:0] thresh_q;
	logic [5:0]  pct_q;
	logic [14:0] min_span_q;

	// Per-channel state, plus the shared calibration flag and display history.
	logic [14:0] last_raw_q  [CHANNELS];
	logic [22:0] ema_q       [CHANNELS];
	logic        started_q   [CHANNELS];
	logic [14:0] cal_low_q   [CHANNELS];
	logic [14:0] cal_high_q  [CHANNELS];
	logic [15:0] sent_lvl_q  [CHANNELS];
	logic        sent_once_q [CHANNELS];
	logic        cal_valid_q;
	logic [7:0]  shown_q;
	logic        shown_once_q;

	// Sequencer and working registers.
	state_t             state_q;
	logic [2:0]         mode_q;
	logic [CW-1:0]      ch_q;
	logic [14:0]        raw_q;
	logic signed [33:0] prod_q;
	logic [22:0]        ema_cur_q;
	logic               div_dead_q;
	logic signed [25:0] lo_q;
	logic signed [25:0] hi_q;
	logic [23:0]        n_q;
	logic [23:0]        d_q;
	logic [15:0]        q_q;
	logic               res_valid_q;
	fac_pkg::res_t      res_q;
	fac_pkg::div_req_t  div_req_q;

	logic                                div_done;
	logic [fac_pkg::DIV_DEN_W-1:0]       div_quot;

	// Combinational helpers.
	logic [14:0]        in_raw;
	logic               in_ch_ok;
	logic [CW-1:0]      in_idx;
	logic [8:0]         alpha_sat;
	logic signed [23:0] delta;
	logic signed [9:0]  alpha_s;
	logic signed [33:0] prod_d;
	logic signed [33:0] step;
	logic signed [33:0] ema_sum;
	logic [22:0]        ema_new;
	logic signed [15:0] span;
	logic               span_zero;
	logic [20:0]        span_pct;
	logic [22:0]        dead;
	logic signed [25:0] ema_s;
	logic [7:0]         level;
	logic [16:0]        q_round;
	logic [15:0]        diff;
	logic               send;
	logic               disp;
	logic               res_free;
	logic               cap_last;

	fac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Input decode: negative readings clamp to zero.
	always_comb begin
		in_raw   = req.sample[15] ? 15'd0 : req.sample[14:0];
		in_ch_ok = 32'(req.channel) < CHANNELS;
		in_idx   = CW'(req.channel);
	end

	// Average update: alpha/256 times the distance to the new reading, rounded to nearest.
	always_comb begin
		alpha_sat = (alpha_q > fac_pkg::ALPHA_MAX) ? fac_pkg::ALPHA_MAX : alpha_q;
		alpha_s   = $signed({1'b0, alpha_sat});
		delta     = $signed({1'b0, raw_q, 8'b0}) - $signed({1'b0, ema_q[ch_q]});
		prod_d    = 34'(alpha_s) * 34'(delta);
		step      = (prod_q + 34'sd128) >>> 8;
		ema_sum   = $signed({11'b0, ema_q[ch_q]}) + step;
		ema_new   = started_q[ch_q] ? ema_sum[22:0] : {raw_q, 8'b0};
	end

	// Calibrated span and dead zone.
	always_comb begin
		span      = $signed({1'b0, cal_high_q[ch_q]}) - $signed({1'b0, cal_low_q[ch_q]});
		span_zero = span[15] || (span[14:0] < min_span_q);
		span_pct  = span[14:0] * pct_q;
		dead      = div_quot[22:0];
		ema_s     = $signed({3'b0, ema_cur_q});
	end

	// Level rounding and change detection.
	always_comb begin
		q_round  = 17'(q_q) + 17'd128;
		level    = (q_round[16:8] > 9'd255) ? 8'd255 : q_round[15:8];
		diff     = (q_q > sent_lvl_q[ch_q]) ? (q_q - sent_lvl_q[ch_q])
		                                    : (sent_lvl_q[ch_q] - q_q);
		send     = !sent_once_q[ch_q] || (diff >= thresh_q);
		disp     = (ch_q == '0) && (!shown_once_q || (level != shown_q));
		res_free = !res_valid_q || res_ready;
		cap_last = ch_q == CW'(CHANNELS - 1);
	end

	// Sequencer, configuration and reset-cleared state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			alpha_q      <= fac_pkg::ALPHA_RST;
			thresh_q     <= fac_pkg::THRESHOLD_RST;
			pct_q        <= fac_pkg::DEAD_PCT_RST;
			min_span_q   <= fac_pkg::MIN_SPAN_RST;
			cal_valid_q  <= 1'b0;
			shown_once_q <= 1'b0;
			res_valid_q  <= 1'b0;
			div_req_q    <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				last_raw_q[i]  <= '0;
				ema_q[i]       <= '0;
				started_q[i]   <= 1'b0;
				cal_low_q[i]   <= '0;
				cal_high_q[i]  <= '0;
				sent_once_q[i] <= 1'b0;
			end
		end else begin
			div_req_q.start <= 1'b0;
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				unique case (cfg_idx)
					fac_pkg::REG_ALPHA:     alpha_q    <= cfg_data[8:0];
					fac_pkg::REG_THRESHOLD: thresh_q   <= cfg_data;
					fac_pkg::REG_DEAD_PCT:  pct_q      <= cfg_data[5:0];
					fac_pkg::REG_MIN_SPAN:  min_span_q <= cfg_data[14:0];
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						mode_q <= req.mode;
						ch_q   <= in_idx;
						raw_q  <= in_raw;
						case (req.mode)
							fac_pkg::MODE_SAMPLE: begin
								if (in_ch_ok) begin
									state_q <= S_EMA;
								end
							end
							fac_pkg::MODE_CAP_LOW, fac_pkg::MODE_CAP_HIGH: begin
								ch_q    <= '0;
								state_q <= S_CAP;
							end
							fac_pkg::MODE_LOAD_LOW: begin
								if (in_ch_ok) begin
									cal_low_q[in_idx] <= in_raw;
								end
							end
							fac_pkg::MODE_LOAD_HI: begin
								if (in_ch_ok) begin
									cal_high_q[in_idx] <= in_raw;
									cal_valid_q        <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				S_EMA: begin
					prod_q  <= prod_d;
					state_q <= S_UPD;
				end
				S_UPD: begin
					ema_q[ch_q]      <= ema_new;
					started_q[ch_q]  <= 1'b1;
					last_raw_q[ch_q] <= raw_q;
					ema_cur_q        <= ema_new;
					state_q          <= S_MAP;
				end
				S_MAP: begin
					// Uncalibrated: scale over full range. Calibrated: a too-short span gives zero, else find the dead zone first.
					if (!cal_valid_q) begin
						div_req_q.start <= 1'b1;
						div_req_q.num   <= 40'({ema_cur_q, 8'b0}) - 40'(ema_cur_q)
						                   + fac_pkg::UNCAL_ROUND;
						div_req_q.den   <= fac_pkg::UNCAL_DEN;
						div_dead_q      <= 1'b0;
						state_q         <= S_DIV;
					end else if (span_zero) begin
						q_q     <= '0;
						state_q <= S_FIN;
					end else begin
						div_req_q.start <= 1'b1;
						div_req_q.num   <= 40'({span_pct, 8'b0}) + fac_pkg::PCT_ROUND;
						div_req_q.den   <= fac_pkg::PCT_DEN;
						div_dead_q      <= 1'b1;
						state_q         <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (div_dead_q) begin
							lo_q    <= $signed({3'b0, cal_low_q[ch_q], 8'b0})
							           + $signed({3'b0, dead});
							hi_q    <= $signed({3'b0, cal_high_q[ch_q], 8'b0})
							           - $signed({3'b0, dead});
							state_q <= S_CMP;
						end else begin
							q_q     <= div_quot[15:0];
							state_q <= S_FIN;
						end
					end
				end
				S_CMP: begin
					// At or below the low edge gives zero, at or above the high edge full scale.
					if (ema_s <= lo_q) begin
						q_q     <= '0;
						state_q <= S_FIN;
					end else if (ema_s >= hi_q) begin
						q_q     <= fac_pkg::FULL_Q8;
						state_q <= S_FIN;
					end else begin
						n_q     <= 24'(ema_s - lo_q);
						d_q     <= 24'(hi_q - lo_q);
						state_q <= S_NUM;
					end
				end
				S_NUM: begin
					// n * 65280 written as n * 65536 - n * 256, plus half the divisor.
					div_req_q.start <= 1'b1;
					div_req_q.num   <= 40'({n_q, 16'b0}) - 40'({n_q, 8'b0})
					                   + 40'(d_q[23:1]);
					div_req_q.den   <= d_q;
					div_dead_q      <= 1'b0;
					state_q         <= S_DIV;
				end
				S_FIN: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						if (send) begin
							sent_once_q[ch_q] <= 1'b1;
						end
						if (disp) begin
							shown_once_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_CAP: begin
					// One report word per channel, bound latched as it goes out.
					if (res_free) begin
						res_valid_q <= 1'b1;
						if (mode_q == fac_pkg::MODE_CAP_LOW) begin
							cal_low_q[ch_q] <= last_raw_q[ch_q];
						end else begin
							cal_high_q[ch_q] <= last_raw_q[ch_q];
						end
						if (cap_last) begin
							if (mode_q == fac_pkg::MODE_CAP_HIGH) begin
								cal_valid_q <= 1'b1;
							end
							state_q <= S_IDLE;
						end else begin
							ch_q <= ch_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result word and last-sent history, which need no reset.
	always_ff @(posedge clk) begin
		if (state_q == S_FIN && res_free) begin
			res_q.kind           <= fac_pkg::KIND_LEVEL;
			res_q.chan_out       <= 2'(ch_q);
			res_q.level          <= level;
			res_q.send           <= send;
			res_q.display_update <= disp;
			res_q.captured_raw   <= '0;
			res_q.last           <= 1'b1;
			if (send) begin
				sent_lvl_q[ch_q] <= q_q;
			end
			if (disp) begin
				shown_q <= level;
			end
		end else if (state_q == S_CAP && res_free) begin
			res_q.kind           <= fac_pkg::KIND_CAPTURE;
			res_q.chan_out       <= 2'(ch_q);
			res_q.level          <= '0;
			res_q.send           <= 1'b0;
			res_q.display_update <= 1'b0;
			res_q.captured_raw   <= last_raw_q[ch_q];
			res_q.last           <= cap_last;
		end
	end

	assign req_ready = state_q == S_IDLE;
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

[tb/sv/fader_adc_conditioner_tb.sv]
// Self-checking bench for the fader ADC conditioner: a table of directed
// words, then randomised phases under several register settings.
// Depends on fac_pkg and the fader_adc_conditioner RTL.
`timescale 1ns / 1ps

module fader_adc_conditioner_tb;
	import fac_pkg::*;

	localparam int CHANNELS        = 4;
	localparam int PHASES          = 8;
	localparam int WORDS_PER_PHASE = 38;
	localparam int SETTLE_CYCLES   = 100;
	localparam int CYCLE_LIMIT     = 400000;

	// Mode codes that the block ignores.
	localparam logic [2:0] MODE_BAD_0 = 3'd5;
	localparam logic [2:0] MODE_BAD_1 = 3'd6;
	localparam logic [2:0] MODE_BAD_2 = 3'd7;
	localparam logic [2:0] UNUSED_MODES [3] = '{MODE_BAD_0, MODE_BAD_1, MODE_BAD_2};

	localparam logic [1:0] REG_ORDER [4] =
		'{REG_ALPHA, REG_THRESHOLD, REG_DEAD_PCT, REG_MIN_SPAN};

	// Values drawn often so that bounds meet and spans collapse to zero.
	localparam logic signed [15:0] VALUE_POOL [4] =
		'{16'sd0, 16'sd1000, 16'sd2000, 16'sd32767};

	typedef struct packed {
		logic [2:0]         mode;
		logic [1:0]         ch;
		logic signed [15:0] smp;
		logic               typed;
		logic [7:0]         lvl;
		logic               snd;
		logic               dsp;
	} dir_row_t;

	typedef struct packed {
		logic [15:0] alpha, thr, pct, span;
		logic        calm;
	} setting_t;

	// Directed words; the first four carry a level that can be read off directly.
	localparam dir_row_t DIRECTED [26] = '{
		'{MODE_SAMPLE,   2'd0, 16'h0000, 1'b1, 8'd0,   1'b1, 1'b1},
		'{MODE_SAMPLE,   2'd1, 16'h7FFF, 1'b1, 8'd255, 1'b1, 1'b0},
		'{MODE_SAMPLE,   2'd2, 16'h8000, 1'b1, 8'd0,   1'b1, 1'b0},
		'{MODE_SAMPLE,   2'd3, 16'hFFFF, 1'b1, 8'd0,   1'b1, 1'b0},
		'{MODE_SAMPLE,   2'd0, 16'h7FFF, 1'b0, 8'd0,   1'b0, 1'b0},
		'{MODE_SAMPLE,   2'd0, 16'h7FFF, 1'b0, 8'd0,   1'b0, 1'b0},
		'{MODE_BAD_0,    2'd0, 16'h1234, 1'b0, 8'd0,   1'b0, 1'b0},
		'{MODE_BAD_1,    2'd1, 16'hFFFF, 1'b0, 8'd0,   1'b0, 1'b0},
		'{MODE_BAD_2,    2'd3, 16'h7FFF, 1'b0, 8'd0,   1'b0, 1'b0},
		'{MODE_SAMPLE,   2'd1, 16'd100,  1'b0, 8'd0,   1'b0, 1'b0},
		'{MODE_SAMPLE,   2'd2, 16'd200,  1'b0, 8'd0,   1'b0, 1'b0},
		'{MODE_SAMPLE,   2'd3, 16'd300,  1'b0, 8'd0,   1'b0, 1'b0},
		'{MODE_CAP_LOW,  2'd0, 16'h0000, 1'b0, 8'd0,   1'b0, 1'b0},
		'{MODE_LOAD_LOW, 2'd0, 16'h8000, 1'b0, 8'd0,   1'b0, 1'b0},
		'{MODE_SAMPLE,   2'd0, 16'd32000, 1'b0, 8'd0,  1'b0, 1'b0},
		'{MODE_SAMPLE,   2'd1, 16'd30000, 1'b0, 8'd0,  1'b0, 1'b0},
		'{MODE_SAMPLE,   2'd2, 16'd200,  1'b0, 8'd0,   1'b0, 1'b0},
		'{MODE_SAMPLE,   2'd3, 16'd305,  1'b0, 8'd0,   1'b0, 1'b0},
		'{MODE_CAP_HIGH, 2'd2, 16'h0000, 1'b0, 8'd0,   1'b0, 1'b0},
		'{MODE_SAMPLE,   2'd0, 16'd16000, 1'b0, 8'd0,  1'b0, 1'b0},
		'{MODE_SAMPLE,   2'd1, 16'd30000, 1'b0, 8'd0,  1'b0, 1'b0},
		'{MODE_LOAD_HI,  2'd1, 16'd50,   1'b0, 8'd0,   1'b0, 1'b0},
		'{MODE_SAMPLE,   2'd1, 16'd200,  1'b0, 8'd0,   1'b0, 1'b0},
		'{MODE_SAMPLE,   2'd2, 16'd300,  1'b0, 8'd0,   1'b0, 1'b0},
		'{MODE_LOAD_HI,  2'd3, 16'h7FFF, 1'b0, 8'd0,   1'b0, 1'b0},
		'{MODE_SAMPLE,   2'd3, 16'h7FFF, 1'b0, 8'd0,   1'b0, 1'b0}
	};

	// Fixed register settings, extremes first; later phases draw their own.
	localparam setting_t FIXED_SETTINGS [5] = '{
		'{16'd256, 16'd0,     16'd0,  16'd0,     1'b0},
		'{16'd1,   16'd65535, 16'd49, 16'd32767, 1'b0},
		'{16'd0,   16'd128,   16'd50, 16'd0,     1'b0},
		'{16'd511, 16'd512,   16'd63, 16'd5,     1'b1},
		'{16'd77,  16'd256,   16'd2,  16'd10,    1'b0}
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req       = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	res_t        res;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_idx   = REG_ALPHA;
	logic [15:0] cfg_data  = '0;

	int feed_gap_pct    = 11;
	int drain_stall_pct = 11;
	int faults          = 0;
	int cycles          = 0;

	// Predicted block state and register copies.
	logic [8:0]  alpha_now;
	logic [15:0] threshold_now;
	logic [5:0]  dead_pct_now;
	logic [14:0] min_span_now;
	logic [14:0] raw_q [CHANNELS];
	logic [22:0] avg_q8 [CHANNELS];
	logic        avg_seeded [CHANNELS];
	logic [14:0] bound_lo [CHANNELS];
	logic [14:0] bound_hi [CHANNELS];
	logic        bounds_on;
	logic [15:0] sent_lvl [CHANNELS];
	logic        sent_seen [CHANNELS];
	logic [7:0]  shown_lvl;
	logic        shown_seen;

	res_t owed_words [$];

	fader_adc_conditioner #(
		.CHANNELS(CHANNELS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic report_fault(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		faults++;
	endtask

	// Maps a smoothed Q15.8 reading to a Q8.8 level in 0..255.
	function automatic longint level_q8(input int c, input logic [22:0] avg);
		longint span, dz, lo, hi;
		if (!bounds_on)
			return (longint'(avg) * 255 + longint'(UNCAL_ROUND)) / longint'(UNCAL_DEN);
		span = longint'(bound_hi[c]) - longint'(bound_lo[c]);
		// Inverted bounds and short spans both give zero.
		if (span < 0 || span < longint'(min_span_now))
			return 0;
		dz = (span * 256 * longint'(dead_pct_now) + longint'(PCT_ROUND)) / longint'(PCT_DEN);
		lo = longint'(bound_lo[c]) * 256 + dz;
		hi = longint'(bound_hi[c]) * 256 - dz;
		if (longint'(avg) <= lo)
			return 0;
		if (longint'(avg) >= hi)
			return longint'(FULL_Q8);
		return ((longint'(avg) - lo) * longint'(FULL_Q8) + (hi - lo) / 2) / (hi - lo);
	endfunction

	// Updates the predicted state for one accepted word and queues the words it owes.
	task automatic condition_word(input req_t w);
		logic [14:0] raw;
		logic [8:0]  alpha;
		logic [7:0]  lvl;
		longint      stp, q, rounded, diff;
		logic        snd, dsp;
		int          c;
		res_t        r;
		raw = w.sample[15] ? 15'd0 : w.sample[14:0];
		c = w.channel;
		case (w.mode)
		MODE_CAP_LOW, MODE_CAP_HIGH: begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (w.mode == MODE_CAP_LOW)
					bound_lo[i] = raw_q[i];
				else
					bound_hi[i] = raw_q[i];
				r = '0;
				r.kind = KIND_CAPTURE;
				r.chan_out = 2'(i);
				r.captured_raw = raw_q[i];
				r.last = (i == CHANNELS - 1);
				owed_words.push_back(r);
			end
			if (w.mode == MODE_CAP_HIGH)
				bounds_on = 1'b1;
		end
		MODE_LOAD_LOW: begin
			bound_lo[c] = raw;
		end
		MODE_LOAD_HI: begin
			bound_hi[c] = raw;
			bounds_on = 1'b1;
		end
		MODE_SAMPLE: begin
			alpha = (alpha_now > ALPHA_MAX) ? ALPHA_MAX : alpha_now;
			raw_q[c] = raw;
			// The first sample seeds the average; later ones pull it by alpha/256.
			if (!avg_seeded[c]) begin
				avg_q8[c] = {raw, 8'd0};
				avg_seeded[c] = 1'b1;
			end else begin
				stp = (longint'(alpha) * (longint'({raw, 8'd0}) - longint'(avg_q8[c]))
					+ 128) >>> 8;
				avg_q8[c] = 23'(longint'(avg_q8[c]) + stp);
			end
			q = level_q8(c, avg_q8[c]);
			rounded = (q + 128) >> 8;
			lvl = (rounded > 255) ? 8'd255 : 8'(rounded);
			dsp = (c == 0) && (!shown_seen || lvl != shown_lvl);
			if (dsp) begin
				shown_lvl = lvl;
				shown_seen = 1'b1;
			end
			diff = (q > longint'(sent_lvl[c])) ? q - longint'(sent_lvl[c])
				: longint'(sent_lvl[c]) - q;
			snd = !sent_seen[c] || diff >= longint'(threshold_now);
			if (snd) begin
				sent_lvl[c] = 16'(q);
				sent_seen[c] = 1'b1;
			end
			r = '0;
			r.kind = KIND_LEVEL;
			r.chan_out = 2'(c);
			r.level = lvl;
			r.send = snd;
			r.display_update = dsp;
			r.last = 1'b1;
			owed_words.push_back(r);
		end
		default: begin
			// Unknown modes leave the state alone.
		end
		endcase
	endtask

	// Presents one word, with random idle cycles ahead of it, and waits for acceptance.
	task automatic offer_word(input req_t w);
		while ($urandom_range(0, 99) < feed_gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		condition_word(w);
	endtask

	function automatic logic signed [15:0] draw_value();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			return VALUE_POOL[$urandom_range(0, 3)];
		if (pick < 35)
			return 16'($urandom_range(0, 32767)) | 16'h8000;
		if (pick < 45)
			return 16'(1000 + $urandom_range(0, 63));
		return 16'($urandom_range(0, 32767));
	endfunction

	// Mostly samples, with bound loads and captures mixed in and the odd unknown mode.
	function automatic req_t draw_word();
		req_t w;
		int   pick;
		pick = $urandom_range(0, 99);
		w.channel = 2'($urandom_range(0, 3));
		w.sample = draw_value();
		if (pick < 70)
			w.mode = MODE_SAMPLE;
		else if (pick < 78)
			w.mode = MODE_LOAD_LOW;
		else if (pick < 86)
			w.mode = MODE_LOAD_HI;
		else if (pick < 91)
			w.mode = MODE_CAP_LOW;
		else if (pick < 96)
			w.mode = MODE_CAP_HIGH;
		else
			w.mode = UNUSED_MODES[$urandom_range(0, 2)];
		return w;
	endfunction

	// Waits until every owed word has arrived, then lets a load or ignored word finish.
	task automatic settle_block();
		req_valid <= 1'b0;
		while (owed_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_settings(input setting_t s);
		logic [15:0] vals [4];
		vals = '{s.alpha, s.thr, s.pct, s.span};
		for (int k = 0; k < 4; k++) begin
			cfg_we <= 1'b1;
			cfg_idx <= REG_ORDER[k];
			cfg_data <= vals[k];
			@(posedge clk);
			case (REG_ORDER[k])
			REG_ALPHA:     alpha_now = vals[k][8:0];
			REG_THRESHOLD: threshold_now = vals[k];
			REG_DEAD_PCT:  dead_pct_now = vals[k][5:0];
			REG_MIN_SPAN:  min_span_now = vals[k][14:0];
			default: ;
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	task automatic check_field(input string field_name, input int got, input int want);
		if (got != want)
			report_fault($sformatf("%s is %0d, expected %0d", field_name, got, want));
	endtask

	task automatic match_result(input res_t got);
		res_t want;
		if (owed_words.size() == 0) begin
			report_fault($sformatf("word %h arrived with nothing owed", got));
			return;
		end
		want = owed_words.pop_front();
		check_field("kind", got.kind, want.kind);
		check_field("chan_out", got.chan_out, want.chan_out);
		check_field("level", got.level, want.level);
		check_field("send", got.send, want.send);
		check_field("display_update", got.display_update, want.display_update);
		check_field("captured_raw", got.captured_raw, want.captured_raw);
		check_field("last", got.last, want.last);
	endtask

	// Result side: check each accepted word and stall at random.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && res_ready)
				match_result(res);
			res_ready <= ($urandom_range(0, 99) >= drain_stall_pct);
		end
	end

	// Watchdog on the whole run.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Stimulus: reset, directed table, then random phases.
	initial begin
		dir_row_t row;
		req_t     w;
		res_t     want;
		setting_t s;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		alpha_now = ALPHA_RST;
		threshold_now = THRESHOLD_RST;
		dead_pct_now = DEAD_PCT_RST;
		min_span_now = MIN_SPAN_RST;
		for (int c = 0; c < CHANNELS; c++) begin
			raw_q[c] = '0;
			avg_q8[c] = '0;
			avg_seeded[c] = 1'b0;
			bound_lo[c] = '0;
			bound_hi[c] = '0;
			sent_lvl[c] = '0;
			sent_seen[c] = 1'b0;
		end
		bounds_on = 1'b0;
		shown_lvl = '0;
		shown_seen = 1'b0;

		foreach (DIRECTED[i]) begin
			row = DIRECTED[i];
			w.mode = row.mode;
			w.channel = row.ch;
			w.sample = row.smp;
			offer_word(w);
			if (row.typed) begin
				want = '0;
				want.kind = KIND_LEVEL;
				want.chan_out = row.ch;
				want.level = row.lvl;
				want.send = row.snd;
				want.display_update = row.dsp;
				want.last = 1'b1;
				owed_words[owed_words.size() - 1] = want;
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			settle_block();
			if (p < 5) begin
				s = FIXED_SETTINGS[p];
			end else begin
				s.alpha = 16'($urandom_range(0, 511));
				s.thr = 16'($urandom_range(0, 2047));
				s.pct = 16'($urandom_range(0, 63));
				s.span = 16'($urandom_range(0, 300));
				s.calm = 1'b0;
			end
			// One phase runs without any idling on either side.
			feed_gap_pct = s.calm ? 0 : 11;
			drain_stall_pct = s.calm ? 0 : 11;
			program_settings(s);
			repeat (WORDS_PER_PHASE) offer_word(draw_word());
		end
		settle_block();

		if (faults == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[sim.f]
rtl/core/fac_pkg.sv
rtl/core/fac_div.sv
rtl/core/fader_adc_conditioner.sv
tb/sv/fader_adc_conditioner_tb.sv
